[rtl/core/sbda_pkg.sv]
`default_nettype none

package sbda_pkg;

    // default operand width
    localparam int VALUE_BITS_DEF = 32;

    // result character and its bus packing
    localparam int CHAR_BITS     = 6;
    localparam int OUT_DATA_BITS = 8;

    localparam logic [CHAR_BITS-1:0] DIGIT_BASE = CHAR_BITS'(48);
    localparam logic [CHAR_BITS-1:0] MINUS_CHAR = CHAR_BITS'(45);

    localparam int BCD_BITS = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } t_state;

endpackage

`default_nettype wire

[rtl/core/signed_binary_to_decimal_ascii.sv]
// the first character follows the input transaction, the conversion and the leading zero drop
// shift-add-3 conversion takes one magnitude bit per cycle
// leading zeros are dropped one bcd digit per cycle, then one character leaves per cycle while i_m_tready allows
// one number in flight: next input taken once the last character sits in the output register
// reset (synchronous, active low) clears the state machine and the output valid flag
`default_nettype none

module signed_binary_to_decimal_ascii #(
    parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // slave side
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]      i_s_tdata,  // [VALUE_BITS-1:0] value
    // master side
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    output logic [sbda_pkg::OUT_DATA_BITS-1:0]        o_m_tdata,  // [5:0] character
    output logic                                      o_m_tlast   // last
);

    import sbda_pkg::*;

    // decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1)
    localparam int NDIG   = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_W  = NDIG * BCD_BITS;
    localparam int BIT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int DIG_W  = $clog2(NDIG + 1);

    t_state                 r_state, n_state;
    logic [VALUE_BITS-1:0]  r_bin, n_bin;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic [DIG_W-1:0]       r_ndig, n_ndig;
    logic                   r_neg, n_neg;
    logic                   r_m_valid, n_m_valid;
    logic [CHAR_BITS-1:0]   r_char, n_char;
    logic                   r_last, n_last;

    logic [VALUE_BITS-1:0]  raw;
    logic [VALUE_BITS-1:0]  mag;
    logic [BCD_W-1:0]       adj;
    logic [BCD_BITS-1:0]    top_digit;
    logic                   out_load;

    assign raw       = i_s_tdata[VALUE_BITS-1:0];
    assign mag       = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
    assign top_digit = r_bcd[BCD_W-1 -: BCD_BITS];
    assign out_load  = !r_m_valid || i_m_tready;

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*BCD_BITS +: BCD_BITS] >= BCD_BITS'(5)) begin
                adj[d*BCD_BITS +: BCD_BITS] = r_bcd[d*BCD_BITS +: BCD_BITS] + BCD_BITS'(3);
            end else begin
                adj[d*BCD_BITS +: BCD_BITS] = r_bcd[d*BCD_BITS +: BCD_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_bit  <= n_bit;
        r_ndig <= n_ndig;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    always_comb begin
        n_state    = r_state;
        n_bin      = r_bin;
        n_bcd      = r_bcd;
        n_bit      = r_bit;
        n_ndig     = r_ndig;
        n_neg      = r_neg;
        n_char     = r_char;
        n_last     = r_last;
        n_m_valid  = r_m_valid && !i_m_tready;
        o_s_tready = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_bin   = mag;
                    n_neg   = raw[VALUE_BITS-1];
                    n_bcd   = '0;
                    n_bit   = BIT_W'(VALUE_BITS - 1);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = {adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                n_bin = r_bin << 1;
                if (r_bit == '0) begin
                    n_ndig  = DIG_W'(NDIG);
                    n_state = ST_SKIP;
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            ST_SKIP: begin
                // drop leading zeros, keeping at least one digit
                if (top_digit == '0 && r_ndig > DIG_W'(1)) begin
                    n_bcd  = r_bcd << BCD_BITS;
                    n_ndig = r_ndig - DIG_W'(1);
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_load) begin
                    n_m_valid = 1'b1;
                    n_char    = MINUS_CHAR;
                    n_last    = 1'b0;
                    n_state   = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_load) begin
                    n_m_valid = 1'b1;
                    n_char    = DIGIT_BASE + CHAR_BITS'(top_digit);
                    n_last    = (r_ndig == DIG_W'(1));
                    n_bcd     = r_bcd << BCD_BITS;
                    n_ndig    = r_ndig - DIG_W'(1);
                    if (r_ndig == DIG_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {(OUT_DATA_BITS - CHAR_BITS)'(0), r_char};
    assign o_m_tlast  = r_last;

endmodule

`default_nettype wire
